### rtl/text_console_cursor_and_scroll_engine_core_assert.svh
// Assertion macros for the console engine.
`ifndef TEXT_CONSOLE_CURSOR_AND_SCROLL_ENGINE_CORE_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_AND_SCROLL_ENGINE_CORE_ASSERT_SVH
`ifndef SYNTH
`define TCCS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tccs assertion failed");
`define TCCS_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tccs assertion failed");
`else
`define TCCS_ASSERT_IMP(label, clk, rst, ante, cons)
`define TCCS_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

### rtl/tccs_pkg.sv
`timescale 1ns / 1ps
package tccs_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int ROW_W   = $clog2(ROWS);
  localparam int COL_W   = $clog2(COLUMNS);

  localparam logic [7:0]  NEWLINE_CODE = 8'h0A;
  localparam logic [7:0]  NUL_CODE     = 8'h00;
  localparam logic [7:0]  COLOR_RESET  = 8'h07;
  localparam logic [15:0] BLANK_CELL   = 16'h0720;

  localparam int PADDR_W = 3;
  localparam logic [PADDR_W-3:0] REG_TEXT_COLOR = '0;

  typedef enum logic [2:0] {
    CMD_PUT,
    CMD_BACKSPACE,
    CMD_DELETE,
    CMD_UP,
    CMD_DOWN,
    CMD_LEFT,
    CMD_RIGHT,
    CMD_READ
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    SRC_MEM,
    SRC_FILL,
    SRC_BLANK
  } src_t;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } in_req_t;

  typedef struct packed {
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic [10:0] cursor_pos;
    logic [15:0] cell_value;
  } out_rsp_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic sweep;
    logic sweep_clear;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scroll;
    logic sweep_last;
  } dp_status_t;

endpackage

### rtl/text_console_cursor_and_scroll_engine_core.sv
`timescale 1ns / 1ps
// channel   | valid      | stall      | payload
// request   | req_valid  | req_stall  | req (in_req_t)
// response  | rsp_valid  | rsp_stall  | rsp (out_rsp_t)
// config    | APB write: psel, penable, pwrite, pready | pwdata / prdata
//
// A command passes through accept, execute on the screen RAM port and load the response.
// A scroll copies one cell per cycle through the single write port of the screen RAM,
// the bottom row filled at the end.
// After reset a clearing pass writes grey space to all 2000 cells; no request is
// taken during it, configuration writes are.
// A new request is taken while a response waits; a stalled response holds the next one.
module text_console_cursor_and_scroll_engine_core import tccs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  in_req_t            req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output out_rsp_t           rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [7:0] text_color;
  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[PADDR_W-1:2] == REG_TEXT_COLOR);
  assign prdata  = reg_hit ? {24'h000000, text_color} : 32'h00000000;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= COLOR_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      text_color <= pwdata[7:0];
    end
  end

  tccs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .status    (status),
    .cmd       (cmd)
  );

  tccs_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .req        (req),
    .text_color (text_color),
    .rsp        (rsp)
  );

endmodule

### rtl/tccs_ctrl.sv
`timescale 1ns / 1ps
`include "text_console_cursor_and_scroll_engine_core_assert.svh"
module tccs_ctrl import tccs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  state_t state, state_next;
  logic   rsp_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_stall  = 1'b1;
    case (state)
      ST_CLEAR: begin
        cmd.sweep       = 1'b1;
        cmd.sweep_clear = 1'b1;
        if (status.sweep_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = status.scroll ? ST_SCROLL : ST_FINISH;
      end
      ST_SCROLL: begin
        cmd.sweep = 1'b1;
        if (status.sweep_last) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!rsp_valid || !rsp_stall) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    rsp_valid_next = cmd.load_out | (rsp_valid & rsp_stall);
  end

  `TCCS_ASSERT_NXT(a_accept_exec, clk, rst, req_valid && !req_stall, state == ST_EXEC)
  `TCCS_ASSERT_NXT(a_scroll_enter, clk, rst, state == ST_EXEC && status.scroll,
                   state == ST_SCROLL)
  `TCCS_ASSERT_NXT(a_scroll_done, clk, rst, state == ST_SCROLL && status.sweep_last,
                   state == ST_FINISH)
  `TCCS_ASSERT_NXT(a_hold_result, clk, rst, state == ST_FINISH && rsp_valid && rsp_stall,
                   state == ST_FINISH && rsp_valid)

endmodule

### rtl/tccs_dp.sv
`timescale 1ns / 1ps
module tccs_dp import tccs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  ctrl_cmd_t  cmd,
  output dp_status_t status,
  input  in_req_t    req,
  input  logic [7:0] text_color,
  output out_rsp_t   rsp
);

  logic [15:0] mem [CELLS];
  logic [15:0] rdata;

  cmd_t            cmd_q;
  logic [7:0]      char_q;
  logic [4:0]      rrow_q;
  logic [6:0]      rcol_q;
  logic            read_ok;
  logic [ROW_W-1:0] row, row_next, back_row, cell_row;
  logic [COL_W-1:0] col, col_next, back_col, cell_col;
  logic [ROW_W:0]  row_inc;
  logic [COL_W:0]  col_inc;
  logic            at_origin, cell_we, scroll, read_in_range;
  logic [7:0]      cell_char;
  logic [ADDR_W-1:0] cell_addr, read_addr, cnt, wr_addr, copy_addr;
  logic            sweep_last, sweep_copy, wr_pend;
  src_t            wr_src;
  logic            mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [15:0]     mem_wdata, sweep_data;

  assign row_inc   = {1'b0, row} + 1'b1;
  assign col_inc   = {1'b0, col} + 1'b1;
  assign at_origin = (row == '0) && (col == '0);
  assign back_row  = (col == '0) ? row - 1'b1 : row;
  assign back_col  = (col == '0) ? COL_W'(COLUMNS - 1) : col - 1'b1;

  always_comb begin
    row_next  = row;
    col_next  = col;
    cell_we   = 1'b0;
    cell_row  = row;
    cell_col  = col;
    cell_char = NUL_CODE;
    scroll    = 1'b0;
    case (cmd_q)
      CMD_PUT: begin
        if (char_q == NEWLINE_CODE) begin
          col_next = '0;
          if (32'(row_inc) >= ROWS) scroll = 1'b1;
          else row_next = row_inc[ROW_W-1:0];
        end else begin
          cell_we   = 1'b1;
          cell_char = char_q;
          if (32'(col_inc) >= COLUMNS) begin
            col_next = '0;
            if (32'(row_inc) >= ROWS) scroll = 1'b1;
            else row_next = row_inc[ROW_W-1:0];
          end else begin
            col_next = col_inc[COL_W-1:0];
          end
        end
        if (scroll) begin
          row_next = ROW_W'(ROWS - 1);
          col_next = '0;
        end
      end
      CMD_BACKSPACE: begin
        if (!at_origin) begin
          row_next = back_row;
          col_next = back_col;
          cell_we  = 1'b1;
          cell_row = back_row;
          cell_col = back_col;
        end
      end
      CMD_DELETE: cell_we = 1'b1;
      CMD_UP: begin
        if (row != '0) row_next = row - 1'b1;
      end
      CMD_DOWN: begin
        if (32'(row_inc) < ROWS) row_next = row_inc[ROW_W-1:0];
      end
      CMD_LEFT: begin
        if (!at_origin) begin
          row_next = back_row;
          col_next = back_col;
        end
      end
      CMD_RIGHT: begin
        if (32'(col_inc) >= COLUMNS) begin
          if (32'(row_inc) < ROWS) begin
            row_next = row_inc[ROW_W-1:0];
            col_next = '0;
          end
        end else begin
          col_next = col_inc[COL_W-1:0];
        end
      end
      default: ;
    endcase
  end

  assign read_in_range = (32'(rrow_q) < ROWS) && (32'(rcol_q) < COLUMNS);
  assign read_addr     = ADDR_W'(32'(rrow_q) * COLUMNS + 32'(rcol_q));
  assign cell_addr     = ADDR_W'(32'(cell_row) * COLUMNS + 32'(cell_col));

  assign sweep_last = (32'(cnt) == CELLS - 1);
  assign sweep_copy = cmd.sweep && !cmd.sweep_clear && (32'(cnt) < CELLS - COLUMNS);
  assign copy_addr  = ADDR_W'(32'(cnt) + COLUMNS);

  assign status.scroll     = scroll;
  assign status.sweep_last = sweep_last;

  always_comb begin
    case (wr_src)
      SRC_MEM:  sweep_data = rdata;
      SRC_FILL: sweep_data = {text_color, NUL_CODE};
      default:  sweep_data = BLANK_CELL;
    endcase
    if (wr_pend) begin
      mem_we    = 1'b1;
      mem_waddr = wr_addr;
      mem_wdata = sweep_data;
    end else begin
      mem_we    = cmd.exec && cell_we;
      mem_waddr = cell_addr;
      mem_wdata = {text_color, cell_char};
    end
    mem_re    = sweep_copy || (cmd.exec && (cmd_q == CMD_READ) && read_in_range);
    mem_raddr = sweep_copy ? copy_addr : read_addr;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_q  <= cmd_t'(req.command);
      char_q <= req.char_code;
      rrow_q <= req.read_row;
      rcol_q <= req.read_col;
    end
    if (cmd.exec) read_ok <= (cmd_q == CMD_READ) && read_in_range;
    wr_addr <= cnt;
    if (cmd.sweep_clear) wr_src <= SRC_BLANK;
    else if (32'(cnt) < CELLS - COLUMNS) wr_src <= SRC_MEM;
    else wr_src <= SRC_FILL;
    if (cmd.load_out) begin
      rsp.cursor_row <= 5'(row);
      rsp.cursor_col <= 7'(col);
      rsp.cursor_pos <= 11'(32'(row) * COLUMNS + 32'(col));
      rsp.cell_value <= read_ok ? rdata : 16'h0000;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row     <= '0;
      col     <= '0;
      cnt     <= '0;
      wr_pend <= 1'b0;
    end else begin
      if (cmd.exec) begin
        row <= row_next;
        col <= col_next;
      end
      if (cmd.sweep && !sweep_last) cnt <= cnt + 1'b1;
      else cnt <= '0;
      wr_pend <= cmd.sweep;
    end
  end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import tccs_pkg::*;

  class console_scoreboard;
    logic [15:0] cells [CELLS];
    int row;
    int col;
    logic [7:0] color;
    out_rsp_t pending_status[$];
    int errors;

    function new();
      foreach (cells[i]) cells[i] = BLANK_CELL;
      row = 0;
      col = 0;
      color = COLOR_RESET;
      errors = 0;
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    function bit step_back();
      if (row == 0 && col == 0) return 1'b0;
      if (col == 0) begin
        row--;
        col = COLUMNS - 1;
      end else begin
        col--;
      end
      return 1'b1;
    endfunction

    function out_rsp_t run_command(in_req_t r);
      out_rsp_t o;
      logic [15:0] seen;
      seen = '0;
      case (cmd_t'(r.command))
        CMD_PUT: begin
          if (r.char_code == NEWLINE_CODE) begin
            row++;
            col = 0;
          end else begin
            cells[row * COLUMNS + col] = {color, r.char_code};
            col++;
            if (col >= COLUMNS) begin
              col = 0;
              row++;
            end
          end
          // scroll up one row, fill the bottom row with NUL cells in the current color
          if (row >= ROWS) begin
            for (int i = 0; i < CELLS - COLUMNS; i++) cells[i] = cells[i + COLUMNS];
            for (int i = CELLS - COLUMNS; i < CELLS; i++) cells[i] = {color, NUL_CODE};
            row = ROWS - 1;
            col = 0;
          end
        end
        CMD_BACKSPACE: begin
          if (step_back()) cells[row * COLUMNS + col] = {color, NUL_CODE};
        end
        CMD_DELETE: cells[row * COLUMNS + col] = {color, NUL_CODE};
        CMD_UP: begin
          if (row != 0) row--;
        end
        CMD_DOWN: begin
          if (row + 1 < ROWS) row++;
        end
        CMD_LEFT: void'(step_back());
        CMD_RIGHT: begin
          if (col + 1 >= COLUMNS) begin
            if (row + 1 < ROWS) begin
              row++;
              col = 0;
            end
          end else begin
            col++;
          end
        end
        CMD_READ: begin
          if (r.read_row < ROWS && r.read_col < COLUMNS)
            seen = cells[r.read_row * COLUMNS + r.read_col];
        end
        default: ;
      endcase
      o.cursor_row = 5'(row);
      o.cursor_col = 7'(col);
      o.cursor_pos = 11'(row * COLUMNS + col);
      o.cell_value = seen;
      return o;
    endfunction

    function void note_request(in_req_t r);
      pending_status.push_back(run_command(r));
    endfunction

    task check_response(out_rsp_t got);
      out_rsp_t want;
      if (pending_status.size() == 0) begin
        report($sformatf("response with nothing pending: %h", got));
        return;
      end
      want = pending_status.pop_front();
      if (got.cursor_row !== want.cursor_row)
        report($sformatf("cursor_row %0d, want %0d", got.cursor_row, want.cursor_row));
      if (got.cursor_col !== want.cursor_col)
        report($sformatf("cursor_col %0d, want %0d", got.cursor_col, want.cursor_col));
      if (got.cursor_pos !== want.cursor_pos)
        report($sformatf("cursor_pos %0d, want %0d", got.cursor_pos, want.cursor_pos));
      if (got.cell_value !== want.cell_value)
        report($sformatf("cell_value %h, want %h", got.cell_value, want.cell_value));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  in_req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  out_rsp_t rsp;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  bit calm = 1'b0;
  in_req_t req_plan[$];
  console_scoreboard sb;

  text_console_cursor_and_scroll_engine_core dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) sb.check_response(rsp);
      rsp_stall <= !calm && ($urandom_range(0, 99) < 34);
    end
  end

  function automatic void add(cmd_t c, logic [7:0] ch);
    in_req_t r;
    r.command = c;
    r.char_code = ch;
    r.read_row = 5'($urandom);
    r.read_col = 7'($urandom);
    req_plan.push_back(r);
  endfunction

  function automatic void add_read(logic [4:0] rr, logic [6:0] rc);
    in_req_t r;
    r.command = CMD_READ;
    r.char_code = 8'($urandom);
    r.read_row = rr;
    r.read_col = rc;
    req_plan.push_back(r);
  endfunction

  function automatic logic [7:0] pick_char();
    if ($urandom_range(0, 99) < 8) return NEWLINE_CODE;
    return 8'($urandom);
  endfunction

  // reach the bottom, scroll, then walk onto the last cell and push past it
  function automatic void add_corner_run();
    repeat (ROWS) add(CMD_DOWN, 8'($urandom));
    add(CMD_PUT, NEWLINE_CODE);
    add(CMD_LEFT, 8'($urandom));
    add(CMD_DOWN, 8'($urandom));
    add(CMD_RIGHT, 8'($urandom));
    add(CMD_PUT, 8'($urandom));
  endfunction

  function automatic void add_burst();
    cmd_t c;
    case ($urandom_range(0, 9))
      0, 1, 2: repeat ($urandom_range(1, 40)) add(CMD_PUT, pick_char());
      3: repeat ($urandom_range(60, 100)) add(CMD_PUT, 8'($urandom));
      4, 5: begin
        c = cmd_t'($urandom_range(CMD_UP, CMD_RIGHT));
        repeat ($urandom_range(1, 30)) add(c, 8'($urandom));
      end
      6: repeat ($urandom_range(1, 8))
        add($urandom_range(0, 1) ? CMD_BACKSPACE : CMD_DELETE, 8'($urandom));
      7, 8: repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(0, 3) == 0)
          add_read(5'($urandom), 7'($urandom));
        else
          add_read(5'($urandom_range(0, ROWS - 1)), 7'($urandom_range(0, COLUMNS - 1)));
      end
      default: add(cmd_t'($urandom_range(0, 7)), 8'($urandom));
    endcase
  endfunction

  task automatic drive_plan();
    in_req_t item;
    while (req_plan.size() != 0) begin
      if (!calm && $urandom_range(0, 99) < 34) begin
        req_valid <= 1'b0;
        @(posedge clk);
      end else begin
        item = req_plan.pop_front();
        req_valid <= 1'b1;
        req <= item;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        sb.note_request(item);
      end
    end
    req_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending_status.size() != 0) @(posedge clk);
  endtask

  task automatic write_text_color(logic [7:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_TEXT_COLOR, 2'b00};
    pwdata <= {24'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.color = value;
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    add(CMD_BACKSPACE, 8'($urandom));
    add(CMD_LEFT, 8'($urandom));
    add(CMD_UP, 8'($urandom));
    add(CMD_DELETE, 8'($urandom));
    add(CMD_PUT, 8'hFF);
    add(CMD_PUT, 8'h00);
    add_read(5'd0, 7'd0);
    add_read(5'd0, 7'd1);
    add(CMD_PUT, 8'h41);
    add(CMD_LEFT, 8'($urandom));
    add(CMD_BACKSPACE, 8'($urandom));
    add(CMD_PUT, NEWLINE_CODE);
    add(CMD_BACKSPACE, 8'($urandom));
    add(CMD_RIGHT, 8'($urandom));
    add(CMD_LEFT, 8'($urandom));
    add_read(5'd0, 7'(COLUMNS - 1));
    add(CMD_DOWN, 8'($urandom));
    add(CMD_DOWN, 8'($urandom));
    add(CMD_UP, 8'($urandom));
    add_read(5'(ROWS - 1), 7'(COLUMNS - 1));
    add_read(5'd31, 7'd127);
    add_read(5'(ROWS), 7'd0);
    add_read(5'd0, 7'(COLUMNS));
    drive_plan();
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      write_text_color(p == 0 ? 8'hFF : p == 1 ? 8'h00 : 8'($urandom_range(1, 254)));
      calm = (p == 1);
      add_corner_run();
      while (req_plan.size() < 75) add_burst();
      drive_plan();
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (sb.pending_status.size() != 0)
      sb.report($sformatf("%0d responses never arrived", sb.pending_status.size()));
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/tccs_pkg.sv
rtl/tccs_ctrl.sv
rtl/tccs_dp.sv
rtl/text_console_cursor_and_scroll_engine_core.sv
tb/sv/testbench.sv
